FILE: sv/epae_pkg.sv
// Shared constants and tables of the event-plane angle estimator.
// Depends on nothing; used by every module of the block.
package epae_pkg;

  localparam int CHANNELS_DEF     = 16;
  localparam int SIGNAL_WIDTH_DEF = 24;
  localparam int CORDIC_STEPS_DEF = 16;

  localparam int ANGLE_W = 16;   // internal angle width, 2^(ANGLE_W-1) = pi
  localparam int TABLE_CH = 16;  // channels covered by the fixed tables
  localparam int ATAN_N = 24;
  localparam int Q_W = 18;       // normalized Q, Q16
  localparam int R_W = 36;       // recentered value, Q28
  localparam int K_W = 18;       // trig / inverse-sigma operand
  localparam int ZA_W = 34;      // CORDIC angle accumulator

  localparam logic [2:0]  SEC_PLANE = 3'd4;
  localparam logic [23:0] THR_RESET = 24'd2000;

  localparam logic signed [2:0] POS_X [0:1][0:15] = '{
    '{3'sd1, 3'sd1, 3'sd1, 3'sd1, 3'sd3, 3'sd3, 3'sd3, 3'sd3,
      -3'sd3, -3'sd3, -3'sd3, -3'sd3, -3'sd1, -3'sd1, -3'sd1, -3'sd1},
    '{-3'sd1, -3'sd1, -3'sd1, -3'sd1, -3'sd3, -3'sd3, -3'sd3, -3'sd3,
      3'sd1, 3'sd1, 3'sd1, 3'sd1, 3'sd3, 3'sd3, 3'sd3, 3'sd3}};

  localparam logic signed [2:0] POS_Y [0:1][0:15] = '{
    '{-3'sd1, 3'sd1, 3'sd3, -3'sd3, -3'sd1, 3'sd1, 3'sd3, -3'sd3,
      3'sd1, -3'sd1, -3'sd3, 3'sd3, 3'sd1, -3'sd1, -3'sd3, 3'sd3},
    '{-3'sd1, 3'sd1, 3'sd3, -3'sd3, -3'sd1, 3'sd3, 3'sd1, -3'sd3,
      3'sd1, -3'sd1, -3'sd3, 3'sd3, 3'sd1, -3'sd1, -3'sd3, 3'sd3}};

  localparam logic [10:0] GAIN_Q8 [0:1][0:15] = '{
    '{11'd340, 11'd461, 11'd504, 11'd563, 11'd691, 11'd645, 11'd724, 11'd463,
      11'd164, 11'd128, 11'd113, 11'd305, 11'd228, 11'd164, 11'd148, 11'd259},
    '{11'd968, 11'd108, 11'd259, 11'd164, 11'd919, 11'd553, 11'd123, 11'd136,
      11'd520, 11'd294, 11'd366, 11'd545, 11'd297, 11'd246, 11'd177, 11'd1211}};

  function automatic logic [10:0] gain_q8(input logic sd, input logic [3:0] ch);
    return GAIN_Q8[sd][ch];
  endfunction

  // Q14 cos, sin, cos2, sin2 of a tile (k selects the term)
  function automatic logic signed [K_W-1:0] trig_q14(input logic sd,
                                                    input logic [3:0] ch,
                                                    input logic [1:0] k);
    logic signed [2:0] x;
    logic signed [2:0] y;
    logic [2:0] ax;
    logic [2:0] ay;
    logic signed [K_W-1:0] c1;
    logic signed [K_W-1:0] s1;
    logic signed [K_W-1:0] c2;
    logic signed [K_W-1:0] s2;
    logic signed [K_W-1:0] res;
    x  = POS_X[sd][ch];
    y  = POS_Y[sd][ch];
    ax = (x < 0) ? 3'(-x) : 3'(x);
    ay = (y < 0) ? 3'(-y) : 3'(y);
    if (ax == ay) begin
      c1 = 18'sd11585; s1 = 18'sd11585; c2 = 18'sd0; s2 = 18'sd16384;
    end else if (ax < ay) begin
      c1 = 18'sd5181; s1 = 18'sd15543; c2 = -18'sd13107; s2 = 18'sd9830;
    end else begin
      c1 = 18'sd15543; s1 = 18'sd5181; c2 = 18'sd13107; s2 = 18'sd9830;
    end
    if (x < 0) c1 = -c1;
    if (y < 0) s1 = -s1;
    if ((x < 0) != (y < 0)) s2 = -s2;
    case (k)
      2'd0:    res = c1;
      2'd1:    res = s1;
      2'd2:    res = c2;
      default: res = s2;
    endcase
    return res;
  endfunction

  function automatic logic signed [13:0] mean_q16(input logic ord, input logic sd,
                                                  input logic k);
    logic signed [13:0] m;
    case ({ord, sd, k})
      3'b000:  m = -14'sd3032;
      3'b001:  m = 14'sd4749;
      3'b010:  m = -14'sd143;
      3'b011:  m = 14'sd94;
      3'b100:  m = 14'sd2922;
      3'b101:  m = -14'sd1956;
      3'b110:  m = -14'sd173;
      default: m = -14'sd412;
    endcase
    return m;
  endfunction

  function automatic logic signed [K_W-1:0] inv_sigma_q12(input logic ord,
                                                        input logic sd,
                                                        input logic k);
    logic signed [K_W-1:0] v;
    case ({ord, sd, k})
      3'b000:  v = 18'sd19721;
      3'b001:  v = 18'sd27252;
      3'b010:  v = 18'sd20299;
      3'b011:  v = 18'sd37564;
      3'b100:  v = 18'sd38846;
      3'b101:  v = 18'sd31067;
      3'b110:  v = 18'sd34543;
      default: v = 18'sd37764;
    endcase
    return v;
  endfunction

  // atan(2^-i), 2^31 = pi
  function automatic logic [30:0] atan_q31(input logic [4:0] i);
    logic [30:0] a;
    case (i)
      5'd0:    a = 31'd536870912;
      5'd1:    a = 31'd316933406;
      5'd2:    a = 31'd167458907;
      5'd3:    a = 31'd85004756;
      5'd4:    a = 31'd42667331;
      5'd5:    a = 31'd21354465;
      5'd6:    a = 31'd10679838;
      5'd7:    a = 31'd5340245;
      5'd8:    a = 31'd2670163;
      5'd9:    a = 31'd1335087;
      5'd10:   a = 31'd667544;
      5'd11:   a = 31'd333772;
      5'd12:   a = 31'd166886;
      5'd13:   a = 31'd83443;
      5'd14:   a = 31'd41722;
      5'd15:   a = 31'd20861;
      5'd16:   a = 31'd10430;
      5'd17:   a = 31'd5215;
      5'd18:   a = 31'd2608;
      5'd19:   a = 31'd1304;
      5'd20:   a = 31'd652;
      5'd21:   a = 31'd326;
      5'd22:   a = 31'd163;
      5'd23:   a = 31'd81;
      default: a = 31'd0;
    endcase
    return a;
  endfunction

endpackage

FILE: sv/epae_mul.sv
// Shared signed multiplier with registered product.
// Depends on epae_pkg.
module epae_mul #(
  parameter int A_W = 25
) (
  input  logic                              clk,
  input  logic signed [A_W-1:0]             a,
  input  logic signed [epae_pkg::K_W-1:0]   b,
  output logic signed [A_W+epae_pkg::K_W-1:0] p
);
  import epae_pkg::*;

  logic signed [A_W+K_W-1:0] p_r;
  logic signed [A_W+K_W-1:0] p_nxt;

  assign p_nxt = (A_W + K_W)'(a) * (A_W + K_W)'(b);

  always_ff @(posedge clk) begin
    p_r <= p_nxt;
  end

  assign p = p_r;
endmodule

FILE: sv/epae_div.sv
// Bit-serial restoring divider, signed dividend, unsigned divisor,
// quotient truncated toward zero. Depends on epae_pkg.
module epae_div #(
  parameter int N_W = 46,
  parameter int D_W = 28
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic signed [N_W-1:0]           num,
  input  logic [D_W-1:0]                  den,
  output logic                            done,
  output logic signed [epae_pkg::Q_W-1:0] quo
);
  import epae_pkg::*;

  localparam int C_W = $clog2(N_W + 1);

  logic           busy_r, busy_nxt;
  logic           done_r, done_nxt;
  logic [C_W-1:0] cnt_r, cnt_nxt;
  logic [N_W-1:0] q_r, q_nxt;
  logic [D_W-1:0] rem_r, rem_nxt;
  logic [D_W-1:0] den_r, den_nxt;
  logic           neg_r, neg_nxt;
  logic [D_W:0]   trial;
  logic [N_W-1:0] q_signed;

  assign trial = {rem_r, q_r[N_W-1]};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    neg_nxt  = neg_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = C_W'(N_W);
      q_nxt    = num[N_W-1] ? N_W'(-num) : N_W'(num);
      rem_nxt  = '0;
      den_nxt  = den;
      neg_nxt  = num[N_W-1];
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = D_W'(trial - {1'b0, den_r});
        q_nxt   = {q_r[N_W-2:0], 1'b1};
      end else begin
        rem_nxt = D_W'(trial);
        q_nxt   = {q_r[N_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == C_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
  end

  assign q_signed = neg_r ? (~q_r + 1'b1) : q_r;
  assign done     = done_r;
  assign quo      = Q_W'(q_signed);
endmodule

FILE: sv/epae_cordic.sv
// Iterative vectoring CORDIC atan2, one micro-rotation per cycle.
// Depends on epae_pkg.
module epae_cordic #(
  parameter int STEPS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [epae_pkg::R_W-1:0]     x_in,
  input  logic signed [epae_pkg::R_W-1:0]     y_in,
  output logic                                done,
  output logic signed [epae_pkg::ANGLE_W-1:0] angle
);
  import epae_pkg::*;

  localparam int C_W = R_W + 3;
  localparam int SH  = 32 - ANGLE_W;
  localparam logic signed [ZA_W-1:0] PI_Z  = ZA_W'(64'd2147483648);
  localparam logic signed [ZA_W-1:0] RND_Z = ZA_W'(64'd1 << (SH - 1));

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [4:0]            i_r, i_nxt;
  logic signed [C_W-1:0] x_r, x_nxt;
  logic signed [C_W-1:0] y_r, y_nxt;
  logic signed [ZA_W-1:0] z_r, z_nxt;
  logic signed [C_W-1:0] xe, ye, dx, dy;
  logic signed [ZA_W-1:0] at, zr;

  assign xe = C_W'(x_in);
  assign ye = C_W'(y_in);
  assign dx = x_r >>> i_r;
  assign dy = y_r >>> i_r;
  assign at = $signed({3'b000, atan_q31(i_r)});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    i_nxt    = i_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    if (start) begin
      i_nxt = '0;
      if (xe == '0 && ye == '0) begin
        z_nxt    = '0;
        done_nxt = 1'b1;
      end else begin
        busy_nxt = 1'b1;
        if (xe < 0) begin
          z_nxt = (ye >= 0) ? PI_Z : -PI_Z;
          x_nxt = -xe;
          y_nxt = -ye;
        end else begin
          z_nxt = '0;
          x_nxt = xe;
          y_nxt = ye;
        end
      end
    end else if (busy_r) begin
      if (y_r > 0) begin
        x_nxt = x_r + dy;
        y_nxt = y_r - dx;
        z_nxt = z_r + at;
      end else begin
        x_nxt = x_r - dy;
        y_nxt = y_r + dx;
        z_nxt = z_r - at;
      end
      i_nxt = i_r + 1'b1;
      if (i_r == 5'(STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      i_r    <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      i_r    <= i_nxt;
    end
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
  end

  // round to ANGLE_W bits, wrap
  assign zr    = (z_r + RND_Z) >>> SH;
  assign angle = ANGLE_W'(zr);
  assign done  = done_r;
endmodule

FILE: sv/event_plane_angle_estimator_core.sv
// Event-plane angle estimator: top level with hit store and sequencer.
// Depends on epae_pkg, epae_mul, epae_div, epae_cordic.
//
// Usage: one detector hit is a transfer on the in_ channel. Section 4
// hits with channel 1..16 have their summed, clamped charge scaled by a
// per-channel gain and written into a 2 x 16 signal store (a later hit on
// the same slot overwrites it). After a hit without in_last_hit, in_ready
// drops for one cycle while the store is written.
// A hit with in_last_hit set starts the event computation: per side a
// multiply-accumulate pass (S_MUL then S_ACC per channel term, 4 terms per
// channel) and, for a side whose total exceeds the threshold, four serial
// divisions (one quotient bit per cycle, ACC width + 2 bits) and two
// CORDIC runs (one step per cycle). The serial divider dominates. in_ready
// stays low until the result has been loaded into the out_ register.
// The result is one transfer on the out_ channel. If the receiver stalls,
// the result holds and the next hits are still taken; only the next
// event end waits for the output register to free up.
// cfg_ writes the total threshold at any time the block is idle; it is
// always ready. Reset clears the store, sets the threshold to 2000 and
// leaves the output channel empty.
module event_plane_angle_estimator_core #(
  parameter int CHANNELS     = epae_pkg::CHANNELS_DEF,
  parameter int SIGNAL_WIDTH = epae_pkg::SIGNAL_WIDTH_DEF,
  parameter int CORDIC_STEPS = epae_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_side,
  input  logic [2:0]         in_section,
  input  logic [4:0]         in_channel,
  input  logic signed [19:0] in_charge_a,
  input  logic signed [19:0] in_charge_b,
  input  logic               in_last_hit,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_first_angle_neg,
  output logic signed [14:0] out_second_angle_neg,
  output logic signed [15:0] out_first_angle_pos,
  output logic signed [14:0] out_second_angle_pos,
  output logic               out_valid_neg,
  output logic               out_valid_pos,
  output logic               out_both_valid,
  output logic [23:0]        out_total_neg,
  output logic [23:0]        out_total_pos,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [23:0]        cfg_data
);
  import epae_pkg::*;

  localparam int SW      = SIGNAL_WIDTH;
  localparam int LIVE_CH = (CHANNELS < TABLE_CH) ? CHANNELS : TABLE_CH;
  localparam int CH_IW   = $clog2(LIVE_CH);
  localparam int TW      = SW + CH_IW;          // side total
  localparam int ACC_W   = SW + 16 + CH_IW;     // Q14 weighted sums
  localparam int NW      = ACC_W + 2;           // sum * 4
  localparam int MA_W    = (SW + 1 > 20) ? SW + 1 : 20;
  localparam int P_W     = MA_W + K_W;
  localparam int RUN     = (CORDIC_STEPS < ATAN_N) ? CORDIC_STEPS : ATAN_N;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_WR    = 4'd1;
  localparam logic [3:0] S_MUL   = 4'd2;
  localparam logic [3:0] S_ACC   = 4'd3;
  localparam logic [3:0] S_CHK   = 4'd4;
  localparam logic [3:0] S_DIV   = 4'd5;
  localparam logic [3:0] S_DWAIT = 4'd6;
  localparam logic [3:0] S_RMUL  = 4'd7;
  localparam logic [3:0] S_RSTO  = 4'd8;
  localparam logic [3:0] S_COR   = 4'd9;
  localparam logic [3:0] S_CWAIT = 4'd10;
  localparam logic [3:0] S_NEXT  = 4'd11;
  localparam logic [3:0] S_OUT   = 4'd12;

  logic [3:0] st_r, st_nxt;

  // threshold register
  logic [23:0] thr_r;
  always_ff @(posedge clk) begin
    if (!rst_n) thr_r <= THR_RESET;
    else if (cfg_valid) thr_r <= cfg_data;
  end
  assign cfg_ready = 1'b1;

  // captured hit
  logic             hsd_r, hok_r, hlast_r;
  logic [CH_IW-1:0] hidx_r;
  logic [19:0]      hsum_r;
  logic signed [20:0] sum21;
  logic [4:0]       chm1;
  logic             in_fire;

  assign in_fire = in_valid && in_ready;
  assign sum21   = 21'(in_charge_a) + 21'(in_charge_b);
  assign chm1    = in_channel - 5'd1;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      hsd_r   <= in_side;
      hok_r   <= (in_section == SEC_PLANE) && (in_channel != 5'd0) &&
                 ({2'b00, in_channel} <= 7'(LIVE_CH));
      hidx_r  <= chm1[CH_IW-1:0];
      hsum_r  <= (sum21 > 0) ? sum21[19:0] : 20'd0;
      hlast_r <= in_last_hit;
    end
  end

  // gain scaling, Q8 with rounding, saturated to the store width
  logic [30:0]   gp;
  logic [22:0]   gv;
  logic [SW-1:0] sig_wr;
  assign gp = 31'(hsum_r) * 31'(gain_q8(hsd_r, 4'(hidx_r))) + 31'd128;
  assign gv = gp[30:8];
  always_comb begin
    if ({{SW{1'b0}}, gv} > {23'd0, {SW{1'b1}}}) sig_wr = '1;
    else sig_wr = SW'(gv);
  end

  // sequencer registers
  logic             sd_r, sd_nxt;
  logic [CH_IW-1:0] c_r, c_nxt;
  logic [1:0]       k_r, k_nxt;
  logic             ord_r, ord_nxt;
  logic signed [ACC_W-1:0] acc_r [4];
  logic signed [ACC_W-1:0] acc_nxt [4];
  logic [TW-1:0]    tot_r, tot_nxt;
  logic signed [R_W-1:0] r_r [2];
  logic signed [R_W-1:0] r_nxt [2];
  logic signed [15:0] a1_r [2];
  logic signed [15:0] a1_nxt [2];
  logic signed [14:0] a2_r [2];
  logic signed [14:0] a2_nxt [2];
  logic [1:0]       vld_r, vld_nxt;
  logic [23:0]      ts_r [2];
  logic [23:0]      ts_nxt [2];
  logic             clr_store;
  logic             wr_store;

  logic [SW-1:0] store_r [2][LIVE_CH];
  logic [SW-1:0] sig_rd;
  assign sig_rd = store_r[sd_r][c_r];

  always_ff @(posedge clk) begin
    if (!rst_n || clr_store) begin
      for (int s = 0; s < 2; s++)
        for (int c = 0; c < LIVE_CH; c++)
          store_r[s][c] <= '0;
    end else if (wr_store) begin
      store_r[hsd_r][hidx_r] <= sig_wr;
    end
  end

  // shared multiplier
  logic signed [MA_W-1:0] mul_a;
  logic signed [K_W-1:0]  mul_b;
  logic signed [P_W-1:0]  mul_p;
  logic signed [Q_W:0]    diff;
  logic signed [Q_W-1:0]  div_q;
  logic                   div_done;

  assign diff = (Q_W + 1)'(div_q) - (Q_W + 1)'(mean_q16(ord_r, sd_r, k_r[0]));

  always_comb begin
    if (st_r == S_RMUL) begin
      mul_a = MA_W'(diff);
      mul_b = inv_sigma_q12(ord_r, sd_r, k_r[0]);
    end else begin
      mul_a = MA_W'($signed({1'b0, sig_rd}));
      mul_b = trig_q14(sd_r, 4'(c_r), k_r);
    end
  end

  epae_mul #(.A_W(MA_W)) u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  // divider: Q16 normalization of one weighted sum
  logic                  div_start;
  logic signed [NW-1:0]  div_num;
  assign div_num = $signed({acc_r[{ord_r, k_r[0]}], 2'b00});

  epae_div #(.N_W(NW), .D_W(TW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (tot_r),
    .done  (div_done),
    .quo   (div_q)
  );

  // CORDIC
  logic                      cor_start, cor_done;
  logic signed [ANGLE_W-1:0] cor_ang;

  epae_cordic #(.STEPS(RUN)) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cor_start),
    .x_in  (r_r[0]),
    .y_in  (r_r[1]),
    .done  (cor_done),
    .angle (cor_ang)
  );

  // threshold and saturation of the running side total
  logic        tot_ok;
  logic [23:0] tot_sat;
  assign tot_ok  = {24'd0, tot_r} > {{TW{1'b0}}, thr_r};
  assign tot_sat = ({24'd0, tot_r} > {{TW{1'b0}}, 24'hFFFFFF}) ? 24'hFFFFFF
                                                               : 24'(tot_r);

  logic out_valid_r, out_valid_nxt;
  logic out_load;

  always_comb begin
    st_nxt    = st_r;
    sd_nxt    = sd_r;
    c_nxt     = c_r;
    k_nxt     = k_r;
    ord_nxt   = ord_r;
    acc_nxt   = acc_r;
    tot_nxt   = tot_r;
    r_nxt     = r_r;
    a1_nxt    = a1_r;
    a2_nxt    = a2_r;
    vld_nxt   = vld_r;
    ts_nxt    = ts_r;
    wr_store  = 1'b0;
    clr_store = 1'b0;
    div_start = 1'b0;
    cor_start = 1'b0;
    out_load  = 1'b0;
    case (st_r)
      S_IDLE: begin
        if (in_fire) st_nxt = S_WR;
      end
      S_WR: begin
        wr_store = hok_r;
        if (hlast_r) begin
          sd_nxt  = 1'b0;
          c_nxt   = '0;
          k_nxt   = '0;
          tot_nxt = '0;
          for (int i = 0; i < 4; i++) acc_nxt[i] = '0;
          st_nxt = S_MUL;
        end else begin
          st_nxt = S_IDLE;
        end
      end
      S_MUL: st_nxt = S_ACC;
      S_ACC: begin
        acc_nxt[k_r] = acc_r[k_r] + ACC_W'(mul_p);
        if (k_r == 2'd0) tot_nxt = tot_r + TW'(sig_rd);
        k_nxt = k_r + 2'd1;
        if (k_r == 2'd3) begin
          c_nxt = c_r + 1'b1;
          if (c_r == CH_IW'(LIVE_CH - 1)) st_nxt = S_CHK;
          else st_nxt = S_MUL;
        end else begin
          st_nxt = S_MUL;
        end
      end
      S_CHK: begin
        vld_nxt[sd_r] = tot_ok;
        ts_nxt[sd_r]  = tot_sat;
        a1_nxt[sd_r]  = '0;
        a2_nxt[sd_r]  = '0;
        ord_nxt = 1'b0;
        k_nxt   = '0;
        st_nxt  = tot_ok ? S_DIV : S_NEXT;
      end
      S_DIV: begin
        div_start = 1'b1;
        st_nxt    = S_DWAIT;
      end
      S_DWAIT: begin
        if (div_done) st_nxt = S_RMUL;
      end
      S_RMUL: st_nxt = S_RSTO;
      S_RSTO: begin
        r_nxt[k_r[0]] = R_W'(mul_p);
        if (k_r[0]) begin
          k_nxt  = '0;
          st_nxt = S_COR;
        end else begin
          k_nxt  = 2'd1;
          st_nxt = S_DIV;
        end
      end
      S_COR: begin
        cor_start = 1'b1;
        st_nxt    = S_CWAIT;
      end
      S_CWAIT: begin
        if (cor_done) begin
          if (!ord_r) begin
            a1_nxt[sd_r] = 16'(cor_ang);
            ord_nxt      = 1'b1;
            st_nxt       = S_DIV;
          end else begin
            a2_nxt[sd_r] = 15'(cor_ang >>> 1);
            st_nxt       = S_NEXT;
          end
        end
      end
      S_NEXT: begin
        if (!sd_r) begin
          sd_nxt  = 1'b1;
          c_nxt   = '0;
          k_nxt   = '0;
          tot_nxt = '0;
          for (int i = 0; i < 4; i++) acc_nxt[i] = '0;
          st_nxt = S_MUL;
        end else begin
          st_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          clr_store = 1'b1;
          st_nxt    = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  assign in_ready = (st_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      sd_r <= 1'b0;
      c_r  <= '0;
      k_r  <= '0;
      ord_r <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      sd_r  <= sd_nxt;
      c_r   <= c_nxt;
      k_r   <= k_nxt;
      ord_r <= ord_nxt;
    end
    acc_r <= acc_nxt;
    tot_r <= tot_nxt;
    r_r   <= r_nxt;
    a1_r  <= a1_nxt;
    a2_r  <= a2_nxt;
    vld_r <= vld_nxt;
    ts_r  <= ts_nxt;
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (out_load) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else out_valid_r <= out_valid_nxt;
    if (out_load) begin
      out_first_angle_neg  <= a1_r[0];
      out_second_angle_neg <= a2_r[0];
      out_first_angle_pos  <= a1_r[1];
      out_second_angle_pos <= a2_r[1];
      out_valid_neg        <= vld_r[0];
      out_valid_pos        <= vld_r[1];
      out_both_valid       <= vld_r[0] && vld_r[1];
      out_total_neg        <= ts_r[0];
      out_total_pos        <= ts_r[1];
    end
  end

  assign out_valid = out_valid_r;

endmodule
